// ===== hw/rtl/zrs_pkg.sv =====
// Package for the zone run sequencer: beat types, command and zone-state codes.
// Used by zone_run_sequencer; depends on nothing else.
package zrs_pkg;

  typedef enum logic [1:0] {
    FuncTick   = 2'd0,
    FuncAppend = 2'd1,
    FuncStart  = 2'd2,
    FuncStop   = 2'd3
  } zrs_func_e;

  typedef enum logic [1:0] {
    ZoneIdle   = 2'd0,
    ZoneActive = 2'd1,
    ZoneDone   = 2'd2
  } zrs_zone_state_e;

  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned ElapsedW   = 14;
  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};
  localparam int unsigned RelayBits  = 8;

  typedef struct packed {
    zrs_func_e   func;
    logic [3:0]  zone_id;
    logic [7:0]  duration_min;
  } zrs_in_t;

  typedef struct packed {
    logic [7:0]          relay_drive;
    logic [3:0]          active_zone;
    logic                watering;
    logic [ElapsedW-1:0] remaining_seconds;
    logic [15:0]         zone_states;
    logic                zone_completed;
    logic                entry_dropped;
  } zrs_out_t;

endpackage

// ===== hw/rtl/zone_run_sequencer.sv =====
// Zone run sequencer top level: run list, zone timer and result register.
// Depends on zrs_pkg.

// Takes one command beat per cycle (tick, append, start, stop) and returns one result
// beat for each in the cycle after acceptance; a new beat is accepted in every cycle while
// the result register is empty or being drained. The run list sits in a small memory with
// a registered read that always holds the entry at the current list position; a copy of
// the first entry serves restarts. Relay outputs are active low, with at most one low.
// num_zones may be written at any idle time and is clamped to ZONE_COUNT.
module zone_run_sequencer
  import zrs_pkg::*;
#(
  parameter int unsigned ZONE_COUNT = 8,
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  zrs_in_t    in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output zrs_out_t   out_o
);

  localparam int unsigned CntW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AddrW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned Shown  = (ZONE_COUNT < RelayBits) ? ZONE_COUNT : RelayBits;
  localparam logic [4:0]  ZoneMax = 5'(ZONE_COUNT);

  logic [3:0]            num_zones_q;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       pos_q, pos_d;
  logic [3:0]            cur_q, cur_d;
  logic [7:0]            min_q, min_d;
  logic [ElapsedW-1:0]   el_q, el_d;
  zrs_zone_state_e       pzs_q [ZONE_COUNT];
  zrs_zone_state_e       pzs_d [ZONE_COUNT];

  logic [11:0]           mem [LIST_DEPTH];
  logic [11:0]           head_q, first_q, entry, wdata;
  logic                  we;
  logic [AddrW-1:0]      waddr, raddr;

  logic                  accept, out_valid_q, do_next, completed, dropped;
  logic [4:0]            limit;
  logic [ElapsedW-1:0]   total_q, total_d;
  zrs_out_t              out_d, out_q;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign limit      = ({1'b0, num_zones_q} > ZoneMax) ? ZoneMax : {1'b0, num_zones_q};
  assign total_q    = ElapsedW'(min_q) * ElapsedW'(SecPerMin);
  assign total_d    = ElapsedW'(min_d) * ElapsedW'(SecPerMin);
  assign waddr      = count_q[AddrW-1:0];
  assign wdata      = {in_i.zone_id, in_i.duration_min};
  assign raddr      = (pos_d < CntW'(LIST_DEPTH)) ? pos_d[AddrW-1:0] : '0;

  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    min_d     = min_q;
    el_d      = el_q;
    pzs_d     = pzs_q;
    completed = 1'b0;
    dropped   = 1'b0;
    we        = 1'b0;
    do_next   = 1'b0;
    entry     = head_q;

    if (accept) begin
      case (in_i.func)
        FuncTick: begin
          if (cur_q != 4'd0) begin
            if (el_q != ElapsedMax) el_d = el_q + ElapsedW'(1);
            if (el_d >= total_q) begin
              for (int unsigned i = 0; i < ZONE_COUNT; i++) begin
                if ({1'b0, cur_q} == 5'(i + 1)) pzs_d[i] = ZoneDone;
              end
              cur_d     = 4'd0;
              min_d     = 8'd0;
              completed = 1'b1;
              do_next   = 1'b1;
            end
          end
        end
        FuncAppend: begin
          if (count_q < CntW'(LIST_DEPTH)) begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            dropped = 1'b1;
          end
        end
        FuncStart: begin
          cur_d = 4'd0;
          min_d = 8'd0;
          for (int unsigned i = 0; i < ZONE_COUNT; i++) pzs_d[i] = ZoneIdle;
          pos_d   = '0;
          do_next = 1'b1;
          entry   = first_q;
        end
        default: begin
          cur_d   = 4'd0;
          min_d   = 8'd0;
          count_d = '0;
          pos_d   = '0;
          for (int unsigned i = 0; i < ZONE_COUNT; i++) pzs_d[i] = ZoneIdle;
        end
      endcase
    end

    // advance to the next entry; a bad zone number consumes it and halts the run
    if (do_next && (pos_d < count_d)) begin
      pos_d = pos_d + CntW'(1);
      if ((entry[11:8] != 4'd0) && ({1'b0, entry[11:8]} <= limit)) begin
        cur_d = entry[11:8];
        min_d = entry[7:0];
        el_d  = '0;
        for (int unsigned i = 0; i < ZONE_COUNT; i++) begin
          if ({1'b0, entry[11:8]} == 5'(i + 1)) pzs_d[i] = ZoneActive;
        end
      end
    end
  end

  always_comb begin
    out_d = '0;
    for (int unsigned i = 0; i < RelayBits; i++) begin
      out_d.relay_drive[i] = !(cur_d == 4'(i + 1));
    end
    out_d.active_zone = cur_d;
    out_d.watering    = (cur_d != 4'd0);
    if ((cur_d != 4'd0) && (total_d > el_d)) out_d.remaining_seconds = total_d - el_d;
    for (int unsigned i = 0; i < Shown; i++) begin
      out_d.zone_states[2*i +: 2] = pzs_d[i];
    end
    out_d.zone_completed = completed;
    out_d.entry_dropped  = dropped;
  end

  // run list: read the entry at the next position every cycle, forwarding a same-cycle write
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (we && (waddr == raddr)) begin
      head_q <= wdata;
    end else begin
      head_q <= mem[raddr];
    end
    if (we && (waddr == '0)) first_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_zones_q <= 4'd8;
      count_q     <= '0;
      pos_q       <= '0;
      cur_q       <= 4'd0;
      min_q       <= 8'd0;
      el_q        <= '0;
      for (int unsigned i = 0; i < ZONE_COUNT; i++) pzs_q[i] <= ZoneIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) num_zones_q <= cfg_wdata_i;
      count_q <= count_d;
      pos_q   <= pos_d;
      cur_q   <= cur_d;
      min_q   <= min_d;
      el_q    <= el_d;
      pzs_q   <= pzs_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat payload: hold until taken
  always_ff @(posedge clk_i) begin
    if (accept) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
